// ===== rtl/lrupr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  // Configuration register map (register index = paddr[2]).
  localparam logic RegActiveFrames = 1'b0;

  localparam int CfgDataW = 32;
  localparam int ActiveW  = 4;
  localparam int FaultW   = 32;

  localparam logic [ActiveW-1:0] ActiveFramesReset = 4'd8;

  // Status of one lookup pass, handed from the scan unit to the sequencer.
  typedef struct packed {
    logic hit;          // requested page found in an occupied frame
    logic found_empty;  // at least one empty frame seen
    logic found_zero;   // an occupied frame with rank zero seen
  } scan_flags_t;

endpackage

// ===== rtl/lrupr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lrupr_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lrupr_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_scan
// Compare unit for the lookup pass: checks one frame per cycle and keeps the
// hit frame, the first empty frame, the rank-zero frame and the occupancy.
// ----------------------------------------------------------------------------
module lrupr_scan #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        clear_i,
  input  logic                                        chk_i,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] chk_idx_i,
  input  logic                                        entry_valid_i,
  input  logic [PAGE_BITS-1:0]                        entry_page_i,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] entry_rank_i,
  input  logic [PAGE_BITS-1:0]                        req_page_i,
  output lrupr_pkg::scan_flags_t                      flags_o,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] hit_idx_o,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] hit_rank_o,
  output logic [$clog2(FRAMES + 1)-1:0]               used_o,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] empty_idx_o,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] zero_idx_o,
  output logic [PAGE_BITS-1:0]                        zero_page_o
);
  import lrupr_pkg::*;

  localparam int IdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CntW = $clog2(FRAMES + 1);

  scan_flags_t          flags_q, flags_d;
  logic [CntW-1:0]      used_q, used_d;
  logic [IdxW-1:0]      hit_idx_q, hit_idx_d;
  logic [IdxW-1:0]      hit_rank_q, hit_rank_d;
  logic [IdxW-1:0]      empty_idx_q, empty_idx_d;
  logic [IdxW-1:0]      zero_idx_q, zero_idx_d;
  logic [PAGE_BITS-1:0] zero_page_q, zero_page_d;

  always_comb begin
    flags_d     = flags_q;
    used_d      = used_q;
    hit_idx_d   = hit_idx_q;
    hit_rank_d  = hit_rank_q;
    empty_idx_d = empty_idx_q;
    zero_idx_d  = zero_idx_q;
    zero_page_d = zero_page_q;
    if (clear_i) begin
      flags_d = '0;
      used_d  = '0;
    end else if (chk_i) begin
      if (entry_valid_i) begin
        used_d = used_q + CntW'(1);
        if (!flags_q.hit && (entry_page_i == req_page_i)) begin
          flags_d.hit = 1'b1;
          hit_idx_d   = chk_idx_i;
          hit_rank_d  = entry_rank_i;
        end
        if (!flags_q.found_zero && (entry_rank_i == '0)) begin
          flags_d.found_zero = 1'b1;
          zero_idx_d         = chk_idx_i;
          zero_page_d        = entry_page_i;
        end
      end else if (!flags_q.found_empty) begin
        flags_d.found_empty = 1'b1;
        empty_idx_d         = chk_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      used_q  <= '0;
    end else begin
      flags_q <= flags_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q   <= hit_idx_d;
    hit_rank_q  <= hit_rank_d;
    empty_idx_q <= empty_idx_d;
    zero_idx_q  <= zero_idx_d;
    zero_page_q <= zero_page_d;
  end

  assign flags_o     = flags_q;
  assign used_o      = used_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_rank_o  = hit_rank_q;
  assign empty_idx_o = empty_idx_q;
  assign zero_idx_o  = zero_idx_q;
  assign zero_page_o = zero_page_q;

endmodule

// ===== rtl/lru_page_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page-frame tracker with a saturating fault counter.
// Each item takes a lookup pass over the n effective active frames, a rank
// update pass and a result hand-off; no new item is accepted until the
// result is loaded into the output register. The single read port of the
// frame RAM is walked once for lookup and once for the rank update.
// Reset empties all frames, clears the fault count and sets active_frames to 8.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // Request channel
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic [PAGE_BITS-1:0]                        page_i,
  input  logic                                        last_request_i,
  // Result channel
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic                                        hit_o,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] frame_index_o,
  output logic                                        evicted_valid_o,
  output logic [PAGE_BITS-1:0]                        evicted_page_o,
  output logic [lrupr_pkg::FaultW-1:0]                fault_count_o,
  output logic                                        run_done_o,
  // Configuration port
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [2:0]                                  paddr,
  input  logic [lrupr_pkg::CfgDataW-1:0]              pwdata,
  output logic [lrupr_pkg::CfgDataW-1:0]              prdata,
  output logic                                        pready
);
  import lrupr_pkg::*;

  localparam int IdxW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CntW  = $clog2(FRAMES + 1);
  localparam int RankW = IdxW;
  localparam int EntW  = PAGE_BITS + RankW;

  // Sequencer states: lookup pass, rank update pass, then result hand-off.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [ActiveW-1:0]   active_q;
  logic [FRAMES-1:0]    valid_q;
  logic [FaultW-1:0]    fault_q;
  logic [CntW-1:0]      addr_q, addr_d;
  logic                 chk_q, chk_d;
  logic [IdxW-1:0]      chk_idx_q, chk_idx_d;
  logic [PAGE_BITS-1:0] req_page_q;
  logic                 req_last_q;

  logic                 out_valid_q;
  logic                 hit_q;
  logic [IdxW-1:0]      frame_q;
  logic                 ev_valid_q;
  logic [PAGE_BITS-1:0] ev_page_q;
  logic [FaultW-1:0]    fault_out_q;
  logic                 done_q;

  // Effective frame count: zero acts as one, anything above FRAMES as FRAMES.
  logic [CntW-1:0] n_eff;
  always_comb begin
    if (active_q == '0) begin
      n_eff = CntW'(1);
    end else if (32'(active_q) > 32'(FRAMES)) begin
      n_eff = CntW'(FRAMES);
    end else begin
      n_eff = CntW'(active_q);
    end
  end

  // APB register access. pready is tied high, so a write lands in its access cycle.
  logic cfg_write;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == RegActiveFrames);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == RegActiveFrames) ? CfgDataW'(active_q) : '0;

  // Frame RAM: each entry holds {page, recency rank}.
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [EntW-1:0] ram_wdata, ram_rdata;
  logic [PAGE_BITS-1:0] ent_page;
  logic [RankW-1:0]     ent_rank;

  assign ent_page = ram_rdata[EntW-1:RankW];
  assign ent_rank = ram_rdata[RankW-1:0];

  lrupr_ram #(
    .WIDTH (EntW),
    .DEPTH (FRAMES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Lookup pass bookkeeping.
  scan_flags_t     flags;
  logic [IdxW-1:0] hit_idx, hit_rank, empty_idx, zero_idx;
  logic [CntW-1:0] used;
  logic [PAGE_BITS-1:0] zero_page;
  logic            scan_clear;
  logic            in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign scan_clear = in_fire;

  lrupr_scan #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (scan_clear),
    .chk_i         (chk_q && (state_q == S_SCAN)),
    .chk_idx_i     (chk_idx_q),
    .entry_valid_i (valid_q[chk_idx_q]),
    .entry_page_i  (ent_page),
    .entry_rank_i  (ent_rank),
    .req_page_i    (req_page_q),
    .flags_o       (flags),
    .hit_idx_o     (hit_idx),
    .hit_rank_o    (hit_rank),
    .used_o        (used),
    .empty_idx_o   (empty_idx),
    .zero_idx_o    (zero_idx),
    .zero_page_o   (zero_page)
  );

  // Outcome of the lookup. With every frame occupied the ranks form a
  // permutation, so a rank-zero victim always exists.
  logic            evict;
  logic [IdxW-1:0] target;
  logic [RankW-1:0] new_rank;
  assign evict    = !flags.hit && !flags.found_empty;
  assign target   = flags.hit ? hit_idx : (flags.found_empty ? empty_idx : zero_idx);
  assign new_rank = (flags.hit || evict) ? RankW'(used - CntW'(1)) : RankW'(used);

  // Both passes share one address walker; the check stage acts on each read
  // in the cycle after it, because the read data is registered.
  logic issue;
  assign issue     = ((state_q == S_SCAN) || (state_q == S_UPDATE)) && (addr_q < n_eff);
  assign ram_re    = issue;
  assign ram_raddr = addr_q[IdxW-1:0];

  // Rank update: the target frame becomes most recent; frames ranked above
  // the hit frame, or every other frame on an eviction, move down by one.
  logic             dec;
  logic [RankW-1:0] upd_rank;
  always_comb begin
    if (flags.hit) begin
      dec = valid_q[chk_idx_q] && (ent_rank > hit_rank);
    end else if (evict) begin
      dec = (ent_rank != '0);
    end else begin
      dec = 1'b0;
    end
    upd_rank = ent_rank - RankW'(dec);
  end

  assign ram_we    = (state_q == S_UPDATE) && chk_q &&
                     (valid_q[chk_idx_q] || (chk_idx_q == target));
  assign ram_waddr = chk_idx_q;
  assign ram_wdata = (chk_idx_q == target) ? {req_page_q, new_rank}
                                           : {ent_page, upd_rank};

  // Result hand-off into the output register.
  logic              out_load;
  logic [FaultW-1:0] fault_next;
  assign out_load   = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);
  assign fault_next = (flags.hit || (fault_q == '1)) ? fault_q : fault_q + FaultW'(1);

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    chk_d     = issue;
    chk_idx_d = addr_q[IdxW-1:0];
    if (issue) begin
      addr_d = addr_q + CntW'(1);
    end
    unique case (state_q)
      S_IDLE: begin
        addr_d = '0;
        if (in_fire) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issue && !chk_q) begin
          state_d = S_UPDATE;
          addr_d  = '0;
        end
      end
      S_UPDATE: begin
        if (!issue && !chk_q) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      addr_q      <= '0;
      chk_q       <= 1'b0;
      active_q    <= ActiveFramesReset;
      valid_q     <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      chk_q   <= chk_d;
      if (cfg_write) begin
        // A new frame count starts a fresh run.
        active_q <= pwdata[ActiveW-1:0];
        valid_q  <= '0;
        fault_q  <= '0;
      end else if (out_load) begin
        if (req_last_q) begin
          valid_q <= '0;
          fault_q <= '0;
        end else begin
          valid_q[target] <= 1'b1;
          fault_q         <= fault_next;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    if (in_fire) begin
      req_page_q <= page_i;
      req_last_q <= last_request_i;
    end
    if (out_load) begin
      hit_q       <= flags.hit;
      frame_q     <= target;
      ev_valid_q  <= evict;
      ev_page_q   <= evict ? zero_page : '0;
      fault_out_q <= fault_next;
      done_q      <= req_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = frame_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = fault_out_q;
  assign run_done_o      = done_q;

`ifndef SYNTHESIS
  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_valid_o))
    else $error("result reports both a hit and an eviction");

  // Once an item is taken the block stays busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("new item accepted while the previous one is in progress");

  // Occupied frames never exceed the effective frame count.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) <= int'(n_eff))
    else $error("more frames occupied than are active");

  // The update pass never reads the entry it is writing.
  a_ram_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("frame RAM read and write at the same address");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the LRU page replacement block. An in-bench
// predictor tracks the frames, their recency ranks and the fault count, and
// each returned result is compared field by field with the oldest
// prediction. The run covers register access, directed requests, random
// traffic under several frame settings, and a long result back-pressure.
// ----------------------------------------------------------------------------
module tb;

  import lrupr_pkg::*;

  localparam int Frames   = 8;
  localparam int PageBits = 16;

  // The single register sits at index 0; index 1 is decoded but unused.
  localparam logic [2:0] ActiveFramesAddr = {RegActiveFrames, 2'b00};
  localparam logic [2:0] UnusedRegAddr    = {~RegActiveFrames, 2'b00};

  localparam int StallLimit    = 2000;  // cycles without any handshake
  localparam int HoldOffCycles = 400;   // long result stall
  localparam int DrainCycles   = 30;    // settle time before a register write
  localparam int MaxReports    = 10;

  typedef struct packed {
    logic                hit;
    logic [2:0]          frame;
    logic                ev_valid;
    logic [PageBits-1:0] ev_page;
    logic [FaultW-1:0]   faults;
    logic                run_done;
  } lru_result_t;

  // --------------------------------------------------------------------------
  // Block signals
  // --------------------------------------------------------------------------
  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [PageBits-1:0] page_i         = '0;
  logic                last_request_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                hit_o;
  logic [2:0]          frame_index_o;
  logic                evicted_valid_o;
  logic [PageBits-1:0] evicted_page_o;
  logic [FaultW-1:0]   fault_count_o;
  logic                run_done_o;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [2:0]          paddr          = '0;
  logic [CfgDataW-1:0] pwdata         = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  lru_page_replacement #(
    .FRAMES   (Frames),
    .PAGE_BITS(PageBits)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .page_i         (page_i),
    .last_request_i (last_request_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .frame_index_o  (frame_index_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .fault_count_o  (fault_count_o),
    .run_done_o     (run_done_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the frame table and the register.
  // --------------------------------------------------------------------------
  logic [ActiveW-1:0]  active_frames_q;
  logic [PageBits-1:0] frame_page_q [Frames];
  logic                frame_used_q [Frames];
  logic [2:0]          recency_q    [Frames];
  logic [FaultW-1:0]   fault_total_q;

  lru_result_t expected_results [$];
  lru_result_t got_result;
  lru_result_t want_result;

  // Idle control shared between the stimulus tasks and the result sink.
  int unsigned tx_idle_max  = 16;
  int unsigned rx_idle_max  = 16;
  int unsigned hold_cycles  = 0;
  int unsigned stall_cycles = 0;

  // Bookkeeping for the summary.
  int unsigned errors       = 0;
  int unsigned n_requests   = 0;
  int unsigned n_hits       = 0;
  int unsigned n_evictions  = 0;
  int unsigned n_runs       = 0;
  logic [Frames-1:0] settings_seen = '0;

  // A register value of 0 behaves as one frame; values above the frame
  // count behave as the full frame count.
  function automatic int unsigned frames_in_use(logic [ActiveW-1:0] value);
    if (value == '0) return 1;
    if (value > Frames) return Frames;
    return 32'(value);
  endfunction

  // Empties the frame table, the ranks and the fault count. This happens
  // on reset, on every write of the register and after a request marked last.
  function automatic void clear_frames();
    for (int i = 0; i < Frames; i++) begin
      frame_page_q[i] = '0;
      frame_used_q[i] = 1'b0;
      recency_q[i]    = '0;
    end
    fault_total_q = '0;
  endfunction

  // Looks one page up in the predicted frame table, updates the table and
  // returns the result the block should produce. Rank 0 marks the least
  // recently used occupied frame; the highest occupied rank is the newest.
  function automatic lru_result_t lookup_page(logic [PageBits-1:0] page,
                                              logic last);
    lru_result_t r;
    int unsigned n;
    int unsigned used;
    int          f;
    logic [2:0]  old_rank;
    logic        found;
    r    = '0;
    n    = frames_in_use(active_frames_q);
    used = 0;
    f    = 0;
    for (int i = 0; i < n; i++) begin
      if (frame_used_q[i]) begin
        used++;
        if (!r.hit && frame_page_q[i] == page) begin
          r.hit = 1'b1;
          f     = i;
        end
      end
    end
    if (r.hit) begin
      // Frames newer than the hit one each move down by one rank.
      old_rank = recency_q[f];
      for (int i = 0; i < n; i++) begin
        if (frame_used_q[i] && recency_q[i] > old_rank) recency_q[i]--;
      end
      recency_q[f] = 3'(used - 1);
    end else begin
      if (fault_total_q != '1) fault_total_q++;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!found && !frame_used_q[i]) begin
          f     = i;
          found = 1'b1;
        end
      end
      if (found) begin
        frame_used_q[f] = 1'b1;
        recency_q[f]    = 3'(used);
      end else begin
        // All frames occupied: replace the least recently used one.
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (!found && recency_q[i] == '0) begin
            f     = i;
            found = 1'b1;
          end
        end
        r.ev_valid = 1'b1;
        r.ev_page  = frame_page_q[f];
        for (int i = 0; i < n; i++) begin
          if (i != f && recency_q[i] != '0) recency_q[i]--;
        end
        recency_q[f] = 3'(n - 1);
      end
      frame_page_q[f] = page;
    end
    r.frame    = 3'(f);
    r.faults   = fault_total_q;
    r.run_done = last;
    if (last) clear_frames();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Monitor. At every edge it first applies a register write, then predicts
  // an accepted request, then checks an accepted result. That order matters
  // only in principle, since a result never leaves in the cycle its request
  // enters. It also counts cycles without any handshake for the watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_frames_q = ActiveFramesReset;
      clear_frames();
      expected_results.delete();
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (psel && penable && pwrite && pready) begin
        stall_cycles = 0;
        // Only index 0 exists; a write there clears the whole run state.
        if (paddr[2] == RegActiveFrames) begin
          active_frames_q = pwdata[ActiveW-1:0];
          clear_frames();
          settings_seen[frames_in_use(active_frames_q) - 1] = 1'b1;
        end
      end
      if (in_valid_i && in_ready_o) begin
        stall_cycles = 0;
        want_result  = lookup_page(page_i, last_request_i);
        expected_results.push_back(want_result);
        n_requests++;
        if (want_result.hit) n_hits++;
        if (want_result.ev_valid) n_evictions++;
        if (want_result.run_done) n_runs++;
      end
      if (out_valid_o && out_ready_i) begin
        stall_cycles = 0;
        got_result = '{hit: hit_o, frame: frame_index_o, ev_valid: evicted_valid_o,
                       ev_page: evicted_page_o, faults: fault_count_o,
                       run_done: run_done_o};
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("[%0t] result with no request pending: %p", $realtime, got_result);
        end else begin
          want_result = expected_results.pop_front();
          if (got_result.hit      !== want_result.hit      ||
              got_result.frame    !== want_result.frame    ||
              got_result.ev_valid !== want_result.ev_valid ||
              got_result.ev_page  !== want_result.ev_page  ||
              got_result.faults   !== want_result.faults   ||
              got_result.run_done !== want_result.run_done) begin
            errors++;
            if (errors <= MaxReports) begin
              $display("[%0t] mismatch: expected hit=%0b frame=%0d ev=%0b/%h faults=%0d done=%0b",
                       $realtime, want_result.hit, want_result.frame,
                       want_result.ev_valid, want_result.ev_page,
                       want_result.faults, want_result.run_done);
              $display("                 actual hit=%0b frame=%0d ev=%0b/%h faults=%0d done=%0b",
                       got_result.hit, got_result.frame, got_result.ev_valid,
                       got_result.ev_page, got_result.faults, got_result.run_done);
            end
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink. Before each result it waits a random number of cycles, and
  // when a test asks for a hold-off it keeps ready low for that long, counted
  // here, so that the block backs up into its request channel.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      gap = $urandom_range(0, rx_idle_max);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Watchdog: a long stretch with no handshake at all means the block hung.
  initial begin : watchdog
    @(posedge rst_ni);
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("Timeout: no handshake for %0d cycles, %0d results still pending.",
             StallLimit, expected_results.size());
    $display("** lru_page_replacement: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shared stimulus tasks. All of them start and end on a rising edge.
  // --------------------------------------------------------------------------

  // Offers one request after a random gap. Valid stays high after the
  // handshake, so a zero gap sends the next item back to back.
  task automatic send_request(input logic [PageBits-1:0] page, input logic last);
    int unsigned gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    page_i         <= page;
    last_request_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops offering requests and waits until every predicted result has come
  // back, then lets the block settle before the register may be touched.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reads the register back and compares it with the predicted value.
  task automatic check_register();
    logic [CfgDataW-1:0] value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ActiveFramesAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (value !== CfgDataW'(active_frames_q)) begin
      errors++;
      if (errors <= MaxReports)
        $display("[%0t] register read: expected %0d, actual %0d",
                 $realtime, active_frames_q, value);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset value, upper data bits that must be masked off, and a write to
  // the unused index that must change nothing.
  task automatic test_register_access();
    check_register();
    cfg_write(UnusedRegAddr, 32'hFFFF_FFF3);
    check_register();
    cfg_write(ActiveFramesAddr, 32'hFFFF_FFF3);
    check_register();
    cfg_write(ActiveFramesAddr, {28'h0, ActiveFramesReset});
    check_register();
  endtask

  // Short hand-picked sequences: page extremes, filling every frame, hits,
  // LRU replacement, the end of a run, and the odd register values.
  task automatic test_directed_requests();
    // Eight frames: fill all of them, hit twice, then force a replacement.
    send_request(16'h0000, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0000, 1'b0);
    send_request(16'h1234, 1'b0);
    send_request(16'h8000, 1'b0);
    send_request(16'h0001, 1'b0);
    send_request(16'h7FFF, 1'b0);
    send_request(16'hAAAA, 1'b0);
    send_request(16'h5555, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h4321, 1'b0);
    send_request(16'h0000, 1'b1);
    // A write to the unused index must leave resident pages in place.
    send_request(16'hBEEF, 1'b0);
    wait_for_drain();
    cfg_write(UnusedRegAddr, 32'h0000_0001);
    send_request(16'hBEEF, 1'b0);
    wait_for_drain();
    // A register value of zero behaves as a single frame.
    cfg_write(ActiveFramesAddr, 32'hFFFF_FFF0);
    check_register();
    send_request(16'h0001, 1'b0);
    send_request(16'h0002, 1'b0);
    send_request(16'h0002, 1'b1);
    wait_for_drain();
    // A value above the frame count behaves as the full count.
    cfg_write(ActiveFramesAddr, 32'h0000_000F);
    check_register();
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0000, 1'b0);
    send_request(16'hFFFF, 1'b1);
    wait_for_drain();
  endtask

  // Random traffic over a series of frame settings. Most pages come from a
  // small window just wider than the frame count, so hits and replacements
  // both happen often; a few are fully random.
  task automatic test_random_traffic(input int unsigned total);
    int unsigned        per_phase;
    int unsigned        n;
    int unsigned        window;
    logic [ActiveW-1:0] setting;
    logic [PageBits-1:0] base;
    logic [PageBits-1:0] page;
    per_phase = total / 8;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: setting = 4'd1;
        1: setting = 4'd8;
        2: setting = 4'd0;
        3: setting = 4'd15;
        default: setting = ActiveW'($urandom_range(0, 15));
      endcase
      // Phases with no idling on the request side or on the result side alternate with random idling.
      tx_idle_max = (phase % 3 == 0) ? 0 : $urandom_range(1, 16);
      rx_idle_max = (phase % 4 == 1) ? 0 : $urandom_range(1, 16);
      cfg_write(ActiveFramesAddr, {28'($urandom_range(0, 32'h0FFF_FFFF)), setting});
      n      = frames_in_use(setting);
      window = n + 3;
      base   = PageBits'($urandom);
      for (int k = 0; k < per_phase; k++) begin
        if ($urandom_range(0, 9) == 0) page = PageBits'($urandom);
        else page = base + PageBits'($urandom_range(0, window - 1));
        send_request(page, $urandom_range(0, 39) == 0);
        // Now and then the sender waits for every outstanding result.
        if ($urandom_range(0, 149) == 0) wait_for_drain();
      end
      wait_for_drain();
    end
    tx_idle_max = 16;
    rx_idle_max = 16;
  endtask

  // The result side stops for a long stretch while requests keep coming back
  // to back, so the block fills and must hold off its request channel.
  task automatic test_backpressure();
    logic [PageBits-1:0] base;
    tx_idle_max = 0;
    rx_idle_max = 0;
    base        = PageBits'($urandom);
    hold_cycles = HoldOffCycles;
    for (int k = 0; k < 24; k++)
      send_request(base + PageBits'($urandom_range(0, 10)), k == 23);
    wait_for_drain();
    tx_idle_max = 16;
    rx_idle_max = 16;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_directed_requests();
    test_random_traffic(1600);
    test_backpressure();

    wait_for_drain();
    if (expected_results.size() != 0) errors++;

    $display("Run covered %0d requests: %0d hits, %0d replacements, %0d completed runs.",
             n_requests, n_hits, n_evictions, n_runs);
    $display("Frame counts exercised (bit per count): %b; %0d failures found.",
             settings_seen, errors);
    if (errors == 0) begin
      $display("** lru_page_replacement: PASSED **");
    end else begin
      $display("** lru_page_replacement: FAILED **");
    end
    $finish;
  end

endmodule
